// ===== design/bfi_pkg.sv =====
// Shared constants, types and the command decoder of the tape machine.
package bfi_pkg;

  localparam int PROG_DEPTH = 4096;
  localparam int TAPE_DEPTH = 32768;
  localparam int NEST_DEPTH = 256;

  localparam int PROG_AW  = $clog2(PROG_DEPTH);
  localparam int PLEN_W   = PROG_AW + 1;
  localparam int TAPE_AW  = $clog2(TAPE_DEPTH);
  localparam int NEST_AW  = $clog2(NEST_DEPTH);
  localparam int NDEPTH_W = NEST_AW + 1;
  localparam int ERR_W    = 3;

  localparam logic [7:0] CH_RIGHT = 8'h3e;
  localparam logic [7:0] CH_LEFT  = 8'h3c;
  localparam logic [7:0] CH_INC   = 8'h2b;
  localparam logic [7:0] CH_DEC   = 8'h2d;
  localparam logic [7:0] CH_OPEN  = 8'h5b;
  localparam logic [7:0] CH_CLOSE = 8'h5d;
  localparam logic [7:0] CH_EMIT  = 8'h2e;
  localparam logic [7:0] CH_HASH  = 8'h23;

  typedef enum logic [2:0] {
    OP_RIGHT = 3'd0,
    OP_LEFT  = 3'd1,
    OP_INC   = 3'd2,
    OP_DEC   = 3'd3,
    OP_OPEN  = 3'd4,
    OP_CLOSE = 3'd5,
    OP_EMIT  = 3'd6
  } op_e;

  typedef enum logic [ERR_W-1:0] {
    ERR_NONE  = 3'd0,
    ERR_CLOSE = 3'd1,
    ERR_OPEN  = 3'd2,
    ERR_FULL  = 3'd3,
    ERR_EARLY = 3'd4
  } err_e;

  typedef struct packed {
    logic valid;
    op_e  op;
  } dec_t;

  typedef struct packed {
    op_e                op;
    logic [PROG_AW-1:0] target;
  } prog_entry_t;

  function automatic dec_t decode_char(logic [7:0] c);
    dec_t d;
    d.valid = 1'b1;
    d.op    = OP_RIGHT;
    unique case (c)
      CH_RIGHT: d.op = OP_RIGHT;
      CH_LEFT:  d.op = OP_LEFT;
      CH_INC:   d.op = OP_INC;
      CH_DEC:   d.op = OP_DEC;
      CH_OPEN:  d.op = OP_OPEN;
      CH_CLOSE: d.op = OP_CLOSE;
      CH_EMIT:  d.op = OP_EMIT;
      default:  d.valid = 1'b0;
    endcase
    return d;
  endfunction

endpackage

// ===== design/bfi_if.sv =====
// Handshake interfaces for the input and result channels.
interface bfi_in_if;
  logic       valid;
  logic       ready;
  logic       func;
  logic [7:0] prog_char;

  modport source (output valid, output func, output prog_char, input ready);
  modport sink (input valid, input func, input prog_char, output ready);
endinterface

interface bfi_out_if import bfi_pkg::*; ();
  logic             valid;
  logic             ready;
  logic             out_valid;
  logic [7:0]       out_byte;
  logic             halted;
  logic [ERR_W-1:0] error_code;

  modport source (output valid, output out_valid, output out_byte, output halted,
                  output error_code, input ready);
  modport sink (input valid, input out_valid, input out_byte, input halted,
                input error_code, output ready);
endinterface

// ===== design/brainfuck_interpreter_core.sv =====
// Top level of the tape machine: program loader, bracket pairing and step sequencer.
//
//   channel  dir  beat payload                              accepted when
//   in_i     in   func, prog_char                           valid && ready
//   out_o    out  out_valid, out_byte, halted, error_code   valid && ready
//
// Every input beat gives exactly one result beat.
// In a step the program store and the tape are read on accept, and the tape is written back
// in ST_EXEC from the registered read data. A closing bracket also passes through ST_CLOSE_A
// and ST_CLOSE_B, as both jump-target entries are written through the single write port of
// the program store. After reset the tape is cleared one cell a cycle, all 32768 cells, with
// ready held low. A result that is not taken holds the following item in its last cycle.
module brainfuck_interpreter_core import bfi_pkg::*; (
  input  logic clk_i,
  input  logic rst_ni,
  bfi_in_if.sink    in_i,
  bfi_out_if.source out_o
);

  localparam logic [2:0] ST_CLEAR   = 3'd0;
  localparam logic [2:0] ST_IDLE    = 3'd1;
  localparam logic [2:0] ST_EXEC    = 3'd2;
  localparam logic [2:0] ST_CLOSE_A = 3'd3;
  localparam logic [2:0] ST_CLOSE_B = 3'd4;
  localparam logic [2:0] ST_PUSH    = 3'd5;

  logic [2:0]          state_q, state_d;
  logic [TAPE_AW-1:0]  clr_q, clr_d;
  logic [PLEN_W-1:0]   len_q, len_d;
  logic [PLEN_W-1:0]   pc_q, pc_d;
  logic [TAPE_AW-1:0]  dp_q, dp_d;
  logic [NDEPTH_W-1:0] depth_q, depth_d;
  logic                load_done_q, load_done_d;
  err_e                err_q, err_d;
  logic                early_q, early_d;
  logic [PROG_AW-1:0]  open_q, open_d;
  logic                res_emit_q, res_emit_d;
  logic [7:0]          res_byte_q, res_byte_d;

  logic             ovld_q, ovld_d;
  logic             oemit_q, oemit_d;
  logic [7:0]       obyte_q, obyte_d;
  logic             ohalt_q, ohalt_d;
  err_e             ocode_q, ocode_d;

  logic               prog_we, prog_re;
  logic [PROG_AW-1:0] prog_waddr;
  prog_entry_t        prog_wdata, prog_rdata;
  logic               tape_we, tape_re;
  logic [TAPE_AW-1:0] tape_waddr;
  logic [7:0]         tape_wdata, tape_rdata;
  logic               nest_we, nest_re;
  logic [NEST_AW-1:0] nest_waddr, nest_raddr;
  logic [PROG_AW-1:0] nest_wdata, nest_rdata;

  logic accept, out_free, taken;
  dec_t dec;

  bfi_ram #(.Width($bits(prog_entry_t)), .Depth(PROG_DEPTH)) u_prog_ram (
    .clk_i   (clk_i),
    .we_i    (prog_we),
    .waddr_i (prog_waddr),
    .wdata_i (prog_wdata),
    .re_i    (prog_re),
    .raddr_i (pc_q[PROG_AW-1:0]),
    .rdata_o (prog_rdata)
  );

  bfi_ram #(.Width(8), .Depth(TAPE_DEPTH)) u_tape_ram (
    .clk_i   (clk_i),
    .we_i    (tape_we),
    .waddr_i (tape_waddr),
    .wdata_i (tape_wdata),
    .re_i    (tape_re),
    .raddr_i (dp_q),
    .rdata_o (tape_rdata)
  );

  bfi_ram #(.Width(PROG_AW), .Depth(NEST_DEPTH)) u_nest_ram (
    .clk_i   (clk_i),
    .we_i    (nest_we),
    .waddr_i (nest_waddr),
    .wdata_i (nest_wdata),
    .re_i    (nest_re),
    .raddr_i (nest_raddr),
    .rdata_o (nest_rdata)
  );

  assign in_i.ready = (state_q == ST_IDLE);
  assign accept     = in_i.valid && in_i.ready;
  assign out_free   = !ovld_q || out_o.ready;
  assign dec        = decode_char(in_i.prog_char);

  always_comb begin
    state_d     = state_q;
    clr_d       = clr_q;
    len_d       = len_q;
    pc_d        = pc_q;
    dp_d        = dp_q;
    depth_d     = depth_q;
    load_done_d = load_done_q;
    err_d       = err_q;
    early_d     = early_q;
    open_d      = open_q;
    res_emit_d  = res_emit_q;
    res_byte_d  = res_byte_q;
    taken       = 1'b0;

    prog_we    = 1'b0;
    prog_re    = 1'b0;
    prog_waddr = len_q[PROG_AW-1:0];
    prog_wdata = '{op: OP_RIGHT, target: '0};
    tape_we    = 1'b0;
    tape_re    = 1'b0;
    tape_waddr = dp_q;
    tape_wdata = tape_rdata;
    nest_we    = 1'b0;
    nest_re    = 1'b0;
    nest_waddr = depth_q[NEST_AW-1:0];
    nest_wdata = len_q[PROG_AW-1:0];
    nest_raddr = NEST_AW'(depth_q - NDEPTH_W'(1));

    ovld_d  = ovld_q && !out_o.ready;
    oemit_d = oemit_q;
    obyte_d = obyte_q;
    ohalt_d = ohalt_q;
    ocode_d = ocode_q;

    unique case (state_q)
      ST_CLEAR: begin
        tape_we    = 1'b1;
        tape_waddr = clr_q;
        tape_wdata = '0;
        clr_d      = clr_q + TAPE_AW'(1);
        if (clr_q == TAPE_AW'(TAPE_DEPTH - 1)) begin
          state_d = ST_IDLE;
        end
      end
      ST_IDLE: begin
        if (accept) begin
          early_d    = 1'b0;
          res_emit_d = 1'b0;
          res_byte_d = '0;
          state_d    = ST_PUSH;
          if (!in_i.func) begin
            if (err_q == ERR_NONE && !load_done_q) begin
              if (in_i.prog_char == CH_HASH) begin
                if (depth_q != '0) begin
                  err_d = ERR_OPEN;
                end else begin
                  load_done_d = 1'b1;
                end
              end else if (dec.valid) begin
                if (len_q == PLEN_W'(PROG_DEPTH)) begin
                  err_d = ERR_FULL;
                end else if (dec.op == OP_OPEN) begin
                  if (depth_q == NDEPTH_W'(NEST_DEPTH)) begin
                    err_d = ERR_FULL;
                  end else begin
                    nest_we    = 1'b1;
                    depth_d    = depth_q + NDEPTH_W'(1);
                    prog_we    = 1'b1;
                    prog_wdata = '{op: OP_OPEN, target: '0};
                    len_d      = len_q + PLEN_W'(1);
                  end
                end else if (dec.op == OP_CLOSE) begin
                  if (depth_q == '0) begin
                    err_d = ERR_CLOSE;
                  end else begin
                    nest_re = 1'b1;
                    depth_d = depth_q - NDEPTH_W'(1);
                    state_d = ST_CLOSE_A;
                  end
                end else begin
                  prog_we    = 1'b1;
                  prog_wdata = '{op: dec.op, target: '0};
                  len_d      = len_q + PLEN_W'(1);
                end
              end
            end
          end else if (err_q == ERR_NONE) begin
            if (!load_done_q) begin
              early_d = 1'b1;
            end else if (pc_q < len_q) begin
              prog_re = 1'b1;
              tape_re = 1'b1;
              state_d = ST_EXEC;
            end
          end
        end
      end
      ST_EXEC: begin
        pc_d       = pc_q + PLEN_W'(1);
        res_emit_d = 1'b0;
        res_byte_d = '0;
        unique case (prog_rdata.op)
          OP_RIGHT: begin
            dp_d = (dp_q == TAPE_AW'(TAPE_DEPTH - 1)) ? '0 : dp_q + TAPE_AW'(1);
          end
          OP_LEFT: begin
            dp_d = (dp_q == '0) ? TAPE_AW'(TAPE_DEPTH - 1) : dp_q - TAPE_AW'(1);
          end
          OP_INC: begin
            tape_we    = 1'b1;
            tape_wdata = tape_rdata + 8'd1;
          end
          OP_DEC: begin
            tape_we    = 1'b1;
            tape_wdata = tape_rdata - 8'd1;
          end
          OP_OPEN: begin
            if (tape_rdata == '0) begin
              pc_d = {1'b0, prog_rdata.target} + PLEN_W'(1);
            end
          end
          OP_CLOSE: begin
            if (tape_rdata != '0) begin
              pc_d = {1'b0, prog_rdata.target} + PLEN_W'(1);
            end
          end
          OP_EMIT: begin
            res_emit_d = 1'b1;
            res_byte_d = tape_rdata;
          end
          default: begin
          end
        endcase
        if (out_free) begin
          ovld_d  = 1'b1;
          oemit_d = res_emit_d;
          obyte_d = res_byte_d;
          ohalt_d = (pc_d >= len_q);
          ocode_d = ERR_NONE;
          taken   = 1'b1;
          state_d = ST_IDLE;
        end else begin
          state_d = ST_PUSH;
        end
      end
      ST_CLOSE_A: begin
        prog_we    = 1'b1;
        prog_wdata = '{op: OP_CLOSE, target: nest_rdata};
        open_d     = nest_rdata;
        state_d    = ST_CLOSE_B;
      end
      ST_CLOSE_B: begin
        prog_we    = 1'b1;
        prog_waddr = open_q;
        prog_wdata = '{op: OP_OPEN, target: len_q[PROG_AW-1:0]};
        len_d      = len_q + PLEN_W'(1);
        state_d    = ST_PUSH;
      end
      ST_PUSH: begin
        if (out_free) begin
          ovld_d  = 1'b1;
          oemit_d = res_emit_q;
          obyte_d = res_byte_q;
          ohalt_d = load_done_q && (pc_q >= len_q);
          if (err_q != ERR_NONE) begin
            ocode_d = err_q;
          end else if (early_q) begin
            ocode_d = ERR_EARLY;
          end else begin
            ocode_d = ERR_NONE;
          end
          taken   = 1'b1;
          state_d = ST_IDLE;
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_CLEAR;
      clr_q       <= '0;
      len_q       <= '0;
      pc_q        <= '0;
      dp_q        <= '0;
      depth_q     <= '0;
      load_done_q <= 1'b0;
      err_q       <= ERR_NONE;
      early_q     <= 1'b0;
      ovld_q      <= 1'b0;
    end else begin
      state_q     <= state_d;
      clr_q       <= clr_d;
      len_q       <= len_d;
      pc_q        <= pc_d;
      dp_q        <= dp_d;
      depth_q     <= depth_d;
      load_done_q <= load_done_d;
      err_q       <= err_d;
      early_q     <= early_d;
      ovld_q      <= ovld_d;
    end
  end

  always_ff @(posedge clk_i) begin
    open_q     <= open_d;
    res_emit_q <= res_emit_d;
    res_byte_q <= res_byte_d;
    if (taken) begin
      oemit_q <= oemit_d;
      obyte_q <= obyte_d;
      ohalt_q <= ohalt_d;
      ocode_q <= ocode_d;
    end
  end

  assign out_o.valid      = ovld_q;
  assign out_o.out_valid  = oemit_q;
  assign out_o.out_byte   = obyte_q;
  assign out_o.halted     = ohalt_q;
  assign out_o.error_code = ocode_q;

endmodule

// ===== design/bfi_ram.sv =====
// Simple dual-port synchronous RAM with one write port and a registered read port.
module bfi_ram #(
  parameter int Width = 8,
  parameter int Depth = 256
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(Depth)-1:0] waddr_i,
  input  logic [Width-1:0]         wdata_i,
  input  logic                     re_i,
  input  logic [$clog2(Depth)-1:0] raddr_i,
  output logic [Width-1:0]         rdata_o
);

  logic [Width-1:0] mem [Depth];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem[waddr_i] <= wdata_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (re_i) begin
      rdata_o <= mem[raddr_i];
    end
  end

endmodule

// ===== tb/sv/tb.sv =====
`timescale 1ns / 100ps
// Self-checking testbench of the tape machine core: directed table, random programs, predictor.
module tb import bfi_pkg::*; ();

  typedef struct packed {
    logic       out_valid;
    logic [7:0] out_byte;
    logic       halted;
    err_e       err;
  } bf_result_t;

  typedef struct packed {
    logic       func;
    logic [7:0] ch;
    logic       typed;
    err_e       err;
  } dir_row_t;

  typedef enum logic [1:0] {
    IDLE_NONE,
    IDLE_SEND,
    IDLE_RECV,
    IDLE_BOTH
  } idle_phase_e;

  typedef enum logic [2:0] {
    RUN_PROGRAM,
    RUN_CLOSE_ERR,
    RUN_OPEN_ERR,
    RUN_NEST_OVF,
    RUN_PROG_FULL
  } run_mode_e;

  localparam logic FN_LOAD = 1'b0;
  localparam logic FN_STEP = 1'b1;
  localparam int   DIR_ROWS = 25;
  localparam int   PHASE_BEATS = 150;
  localparam int   RANDOM_STEPS = 1700;
  localparam int   STICKY_ITEMS = 1900;
  localparam int   FULL_STICKY_ITEMS = 100;

  localparam dir_row_t DIR_TAB [DIR_ROWS] = '{
    '{FN_STEP, 8'h00,    1'b1, ERR_EARLY},
    '{FN_LOAD, 8'h00,    1'b1, ERR_NONE},
    '{FN_LOAD, 8'hff,    1'b1, ERR_NONE},
    '{FN_STEP, 8'hff,    1'b1, ERR_EARLY},
    '{FN_LOAD, CH_LEFT,  1'b0, ERR_NONE},
    '{FN_LOAD, CH_EMIT,  1'b0, ERR_NONE},
    '{FN_LOAD, CH_INC,   1'b0, ERR_NONE},
    '{FN_LOAD, CH_OPEN,  1'b0, ERR_NONE},
    '{FN_LOAD, CH_DEC,   1'b0, ERR_NONE},
    '{FN_LOAD, CH_CLOSE, 1'b0, ERR_NONE},
    '{FN_LOAD, CH_LEFT,  1'b0, ERR_NONE},
    '{FN_LOAD, CH_DEC,   1'b0, ERR_NONE},
    '{FN_LOAD, CH_EMIT,  1'b0, ERR_NONE},
    '{FN_STEP, 8'h5a,    1'b1, ERR_EARLY},
    '{FN_LOAD, 8'h41,    1'b1, ERR_NONE},
    '{FN_LOAD, CH_RIGHT, 1'b0, ERR_NONE},
    '{FN_LOAD, CH_RIGHT, 1'b0, ERR_NONE},
    '{FN_LOAD, CH_OPEN,  1'b0, ERR_NONE},
    '{FN_LOAD, CH_INC,   1'b0, ERR_NONE},
    '{FN_LOAD, CH_CLOSE, 1'b0, ERR_NONE},
    '{FN_LOAD, CH_INC,   1'b0, ERR_NONE},
    '{FN_LOAD, CH_INC,   1'b0, ERR_NONE},
    '{FN_LOAD, CH_OPEN,  1'b0, ERR_NONE},
    '{FN_LOAD, CH_DEC,   1'b0, ERR_NONE},
    '{FN_LOAD, CH_CLOSE, 1'b0, ERR_NONE}
  };

  logic clk_i;
  logic rst_ni;

  bfi_in_if  in_if ();
  bfi_out_if out_if ();

  brainfuck_interpreter_core u_top (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .in_i   (in_if),
    .out_o  (out_if)
  );

  op_e                 shadow_op    [PROG_DEPTH];
  logic [PROG_AW-1:0]  shadow_jump  [PROG_DEPTH];
  logic [PROG_AW-1:0]  shadow_nest  [NEST_DEPTH];
  logic [7:0]          shadow_tape  [TAPE_DEPTH];
  logic [NDEPTH_W-1:0] shadow_depth;
  logic [PLEN_W-1:0]   shadow_len;
  logic [PLEN_W-1:0]   shadow_pc;
  logic [TAPE_AW-1:0]  shadow_dp;
  logic                shadow_loaded;
  err_e                shadow_err;

  bf_result_t  bf_results_due [$];
  idle_phase_e idle_phase;
  int unsigned beats_sent;
  int unsigned mismatches;

  always begin
    clk_i = 1'b0;
    #5;
    clk_i = 1'b1;
    #5;
  end

  function automatic bf_result_t predict_bf_result(input logic func, input logic [7:0] ch);
    bf_result_t         res;
    op_e                op;
    logic               is_cmd;
    logic [PROG_AW-1:0] pos;
    logic [PROG_AW-1:0] open_at;
    logic [PROG_AW-1:0] next_pc;
    res = '{1'b0, 8'h00, 1'b0, ERR_NONE};
    if (func == FN_LOAD) begin
      is_cmd = 1'b1;
      op     = OP_RIGHT;
      case (ch)
        CH_RIGHT: op = OP_RIGHT;
        CH_LEFT:  op = OP_LEFT;
        CH_INC:   op = OP_INC;
        CH_DEC:   op = OP_DEC;
        CH_OPEN:  op = OP_OPEN;
        CH_CLOSE: op = OP_CLOSE;
        CH_EMIT:  op = OP_EMIT;
        default:  is_cmd = 1'b0;
      endcase
      pos = shadow_len[PROG_AW-1:0];
      if (shadow_err == ERR_NONE && !shadow_loaded) begin
        if (ch == CH_HASH) begin
          if (shadow_depth != '0) shadow_err = ERR_OPEN;
          else shadow_loaded = 1'b1;
        end else if (is_cmd) begin
          if (shadow_len == PLEN_W'(PROG_DEPTH)) begin
            shadow_err = ERR_FULL;
          end else if (op == OP_OPEN && shadow_depth == NDEPTH_W'(NEST_DEPTH)) begin
            shadow_err = ERR_FULL;
          end else if (op == OP_CLOSE && shadow_depth == '0) begin
            shadow_err = ERR_CLOSE;
          end else begin
            if (op == OP_OPEN) begin
              shadow_nest[shadow_depth[NEST_AW-1:0]] = pos;
              shadow_depth = shadow_depth + NDEPTH_W'(1);
            end else if (op == OP_CLOSE) begin
              shadow_depth = shadow_depth - NDEPTH_W'(1);
              open_at = shadow_nest[shadow_depth[NEST_AW-1:0]];
              shadow_jump[open_at] = pos;
              shadow_jump[pos] = open_at;
            end
            shadow_op[pos] = op;
            shadow_len = shadow_len + PLEN_W'(1);
          end
        end
      end
    end else if (shadow_err == ERR_NONE) begin
      if (!shadow_loaded) begin
        res.err = ERR_EARLY;
      end else if (shadow_pc < shadow_len) begin
        next_pc = shadow_pc[PROG_AW-1:0];
        case (shadow_op[next_pc])
          OP_RIGHT: shadow_dp = shadow_dp + TAPE_AW'(1);
          OP_LEFT:  shadow_dp = shadow_dp - TAPE_AW'(1);
          OP_INC:   shadow_tape[shadow_dp] = shadow_tape[shadow_dp] + 8'd1;
          OP_DEC:   shadow_tape[shadow_dp] = shadow_tape[shadow_dp] - 8'd1;
          OP_OPEN:  if (shadow_tape[shadow_dp] == 8'd0) next_pc = shadow_jump[next_pc];
          OP_CLOSE: if (shadow_tape[shadow_dp] != 8'd0) next_pc = shadow_jump[next_pc];
          OP_EMIT: begin
            res.out_valid = 1'b1;
            res.out_byte  = shadow_tape[shadow_dp];
          end
          default: ;
        endcase
        shadow_pc = {1'b0, next_pc} + PLEN_W'(1);
      end
    end
    if (shadow_err != ERR_NONE) res.err = shadow_err;
    res.halted = shadow_loaded && (shadow_pc >= shadow_len);
    return res;
  endfunction

  function automatic int unsigned idle_pct(input logic sender);
    case (idle_phase)
      IDLE_SEND: return sender ? 85 : 0;
      IDLE_RECV: return sender ? 0 : 85;
      IDLE_BOTH: return 17;
      default:   return 0;
    endcase
  endfunction

  function automatic logic [7:0] simple_cmd();
    int unsigned roll;
    roll = $urandom_range(19, 0);
    if (roll < 4) return CH_RIGHT;
    else if (roll < 8) return CH_LEFT;
    else if (roll < 13) return CH_INC;
    else if (roll < 17) return CH_DEC;
    else return CH_EMIT;
  endfunction

  task automatic queue_result(input bf_result_t res);
    bf_results_due.insert(bf_results_due.size(), res);
  endtask

  task automatic wait_results_drained();
    in_if.valid <= 1'b0;
    @(negedge clk_i);
    while (bf_results_due.size() != 0) @(negedge clk_i);
  endtask

  task automatic send_item(input logic func, input logic [7:0] ch, input logic typed = 1'b0,
                           input bf_result_t typed_res = '0);
    bf_result_t res;
    while ($urandom_range(99, 0) < idle_pct(1'b1)) begin
      in_if.valid <= 1'b0;
      @(negedge clk_i);
    end
    in_if.valid     <= 1'b1;
    in_if.func      <= func;
    in_if.prog_char <= ch;
    @(posedge clk_i);
    while (!in_if.ready) @(posedge clk_i);
    res = predict_bf_result(func, ch);
    queue_result(typed ? typed_res : res);
    @(negedge clk_i);
    beats_sent++;
    if (beats_sent % PHASE_BEATS == 0) begin
      idle_phase = idle_phase_e'(idle_phase + 2'd1);
      wait_results_drained();
    end
  endtask

  task automatic load_program(input int unsigned n_cmds, input int unsigned max_nest);
    int unsigned left;
    int unsigned depth;
    int unsigned roll;
    logic [7:0]  c;
    left  = n_cmds;
    depth = 0;
    while (left > 0 || depth > 0) begin
      roll = $urandom_range(99, 0);
      if (roll < 8) begin
        do c = 8'($urandom_range(255, 0));
        while (c inside {CH_RIGHT, CH_LEFT, CH_INC, CH_DEC, CH_OPEN, CH_CLOSE, CH_EMIT,
                         CH_HASH});
        send_item(FN_LOAD, c);
      end else if (roll < 12) begin
        send_item(FN_STEP, 8'($urandom_range(255, 0)));
      end else begin
        if (depth > 0 && (left <= depth || roll < 26)) begin
          c = CH_CLOSE;
          depth--;
        end else if (depth < max_nest && left > depth + 1 && roll < 38) begin
          c = CH_OPEN;
          depth++;
        end else begin
          c = simple_cmd();
        end
        send_item(FN_LOAD, c);
        if (left > 0) left--;
      end
    end
  endtask

  always @(negedge clk_i) begin
    out_if.ready <= ($urandom_range(99, 0) >= idle_pct(1'b0));
  end

  always @(posedge clk_i) begin : result_check
    bf_result_t want;
    if (out_if.valid === 1'b1 && out_if.ready === 1'b1) begin
      if (bf_results_due.size() == 0) begin
        $error("result beat with no expectation waiting");
        mismatches++;
      end else begin
        want = bf_results_due.pop_front();
        if (out_if.out_valid !== want.out_valid) begin
          $error("out_valid: expected %0d, actual %0d", want.out_valid, out_if.out_valid);
          mismatches++;
        end
        if (out_if.out_byte !== want.out_byte) begin
          $error("out_byte: expected %0d, actual %0d", want.out_byte, out_if.out_byte);
          mismatches++;
        end
        if (out_if.halted !== want.halted) begin
          $error("halted: expected %0d, actual %0d", want.halted, out_if.halted);
          mismatches++;
        end
        if (out_if.error_code !== want.err) begin
          $error("error_code: expected %0d, actual %0d", want.err, out_if.error_code);
          mismatches++;
        end
      end
    end
  end

  initial begin : stimulus
    run_mode_e   mode;
    int unsigned steps;
    int unsigned n_sticky;
    dir_row_t    row;
    bf_result_t  typed_res;
    rst_ni          = 1'b0;
    in_if.valid     = 1'b0;
    in_if.func      = FN_LOAD;
    in_if.prog_char = 8'h00;
    out_if.ready    = 1'b0;
    idle_phase      = IDLE_NONE;
    beats_sent      = 0;
    mismatches      = 0;
    for (int i = 0; i < TAPE_DEPTH; i++) shadow_tape[i] = 8'h00;
    shadow_depth  = '0;
    shadow_len    = '0;
    shadow_pc     = '0;
    shadow_dp     = '0;
    shadow_loaded = 1'b0;
    shadow_err    = ERR_NONE;
    case ($urandom_range(7, 0))
      4:       mode = RUN_CLOSE_ERR;
      5:       mode = RUN_OPEN_ERR;
      6:       mode = RUN_NEST_OVF;
      7:       mode = RUN_PROG_FULL;
      default: mode = RUN_PROGRAM;
    endcase
    repeat (6) @(negedge clk_i);
    rst_ni <= 1'b1;

    for (int i = 0; i < DIR_ROWS; i++) begin
      row       = DIR_TAB[i];
      typed_res = '{1'b0, 8'h00, 1'b0, row.err};
      send_item(row.func, row.ch, row.typed, typed_res);
    end

    case (mode)
      RUN_PROGRAM: begin
        if ($urandom_range(1, 0) != 0) load_program($urandom_range(80, 20), 8);
        else load_program($urandom_range(400, 100), 8);
        send_item(FN_LOAD, CH_HASH);
        wait_results_drained();
        steps = 0;
        while (steps < RANDOM_STEPS) begin
          if ($urandom_range(99, 0) < 7) begin
            send_item(FN_LOAD, 8'($urandom_range(255, 0)));
          end else begin
            send_item(FN_STEP, 8'($urandom_range(255, 0)));
            steps++;
          end
        end
      end
      RUN_CLOSE_ERR: begin
        load_program($urandom_range(60, 10), 6);
        send_item(FN_LOAD, CH_CLOSE);
      end
      RUN_OPEN_ERR: begin
        load_program($urandom_range(60, 10), 6);
        send_item(FN_LOAD, CH_OPEN);
        load_program($urandom_range(20, 0), 4);
        send_item(FN_LOAD, CH_HASH);
      end
      RUN_NEST_OVF: begin
        load_program($urandom_range(60, 10), 6);
        while (shadow_err == ERR_NONE) send_item(FN_LOAD, CH_OPEN);
      end
      default: begin
        load_program($urandom_range(300, 100), 8);
        while (shadow_len < PLEN_W'(PROG_DEPTH)) send_item(FN_LOAD, simple_cmd());
        send_item(FN_LOAD, ($urandom_range(1, 0) != 0) ? CH_OPEN : simple_cmd());
      end
    endcase

    if (mode != RUN_PROGRAM) begin
      wait_results_drained();
      n_sticky = (mode == RUN_PROG_FULL) ? FULL_STICKY_ITEMS : STICKY_ITEMS;
      repeat (n_sticky) begin
        if ($urandom_range(3, 0) == 0) send_item(FN_LOAD, CH_HASH);
        else send_item(1'($urandom_range(1, 0)), 8'($urandom_range(255, 0)));
      end
    end

    wait_results_drained();
    repeat (32) @(negedge clk_i);
    if (mismatches == 0 && bf_results_due.size() == 0) begin
      $display("PASS brainfuck_interpreter_core");
    end else begin
      $display("FAIL brainfuck_interpreter_core");
    end
    $finish;
  end

  initial begin : watchdog
    #15_000_000;
    $display("FAIL brainfuck_interpreter_core");
    $finish;
  end

endmodule
